>>> rtl/bsp_pkg.sv
// Package for the Bayer superpixel split block: sizes, codes and types.
package bsp_pkg;

  localparam int unsigned MaxWidth  = 8192;
  localparam int unsigned MaxHeight = 8192;

  localparam int unsigned PixW   = 16;
  localparam int unsigned GreenW = PixW + 1;
  localparam int unsigned DimW   = 14;
  localparam int unsigned ColW   = $clog2(MaxWidth);
  localparam int unsigned RowW   = $clog2(MaxHeight);

  // Line buffer holds one even/odd column pair per entry.
  localparam int unsigned PairDepth = MaxWidth / 2;
  localparam int unsigned PairW     = 2 * PixW;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef logic [PixW-1:0]   pix_t;
  typedef logic [GreenW-1:0] green_t;
  typedef logic [DimW-1:0]   dim_t;

  localparam pix_t   SatOut      = '1;
  localparam green_t SatOutGreen = {1'b1, {(GreenW-2){1'b1}}, 1'b0};

  localparam dim_t ResetWidth  = DimW'(MaxWidth);
  localparam dim_t ResetHeight = DimW'(MaxHeight);
  localparam pix_t ResetSat    = PixW'(65500);

  typedef enum logic [1:0] {
    PatRggb = 2'd0,
    PatBggr = 2'd1,
    PatGrbg = 2'd2,
    PatGbrg = 2'd3
  } pattern_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgBayerPat    = 2'd2,
    CfgSatLevel    = 2'd3
  } cfg_idx_e;

endpackage

>>> rtl/bsp_pixel_if.sv
// Stream interface carrying raw mosaic pixels.
interface bsp_pixel_if;
  logic          valid;
  logic          ready;
  bsp_pkg::pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

>>> rtl/bsp_super_if.sv
// Stream interface carrying superpixel results.
interface bsp_super_if;
  logic            valid;
  logic            ready;
  bsp_pkg::pix_t   red;
  bsp_pkg::green_t green_doubled;
  bsp_pkg::pix_t   blue;
  logic            frame_end;

  modport source (output valid, output red, output green_doubled, output blue,
                  output frame_end, input ready);
  modport sink   (input valid, input red, input green_doubled, input blue,
                  input frame_end, output ready);
endinterface

>>> rtl/bayer_superpixel_split_core.sv
// Bayer 2x2 superpixel binning: line buffer, cell assembly and result register.
// Throughput: one pixel per cycle, set by the single-port-per-side pair line buffer.
// Latency: the result of a closing pixel is valid in the output register the next cycle.
// Input ready drops only while the output register is full and the sink stalls.
// Reset clears counters, held pixel and output valid, and loads register defaults;
// the line buffer is not cleared and needs no clearing pass.
module bayer_superpixel_split_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bsp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bsp_pkg::CfgDataW-1:0]    cfg_wdata_i,
  bsp_pixel_if.sink                       pixel_i,
  bsp_super_if.source                     superpixel_o
);

  localparam int unsigned AddrW = $clog2(bsp_pkg::PairDepth);

  // Configuration registers
  bsp_pkg::dim_t     width_q, width_d;
  bsp_pkg::dim_t     height_q, height_d;
  bsp_pkg::pattern_e pattern_q, pattern_d;
  bsp_pkg::pix_t     sat_q, sat_d;

  // Position and held pixel
  logic [bsp_pkg::ColW-1:0] col_q, col_d;
  logic [bsp_pkg::RowW-1:0] row_q, row_d;
  bsp_pkg::pix_t            left_q, left_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  bsp_pkg::pix_t   red_q, red_d;
  bsp_pkg::green_t green_q, green_d;
  bsp_pkg::pix_t   blue_q, blue_d;
  logic            fend_q, fend_d;

  logic          in_fire;
  logic          out_load;
  logic          dim_write;
  bsp_pkg::dim_t w_eff, h_eff, w_last_cell, h_last_cell;
  logic          col_last, row_last;

  logic                          mem_we, mem_re;
  logic [bsp_pkg::PairW-1:0]     mem_wdata, mem_rdata;
  logic [AddrW-1:0]              mem_addr;

  bsp_pkg::pix_t cell0, cell1, cell2, cell3;
  logic          sat0, sat1, sat2, sat3;
  bsp_pkg::pix_t red_raw, blue_raw, g_a, g_b;
  logic          red_sat, blue_sat, green_sat;

  assign pixel_i.ready = !out_valid_q || superpixel_o.ready;
  assign in_fire       = pixel_i.valid && pixel_i.ready;
  assign out_load      = in_fire && row_q[0] && col_q[0];

  // Effective dimensions, clamped to [2, max]
  always_comb begin
    if (width_q < bsp_pkg::dim_t'(2)) begin
      w_eff = bsp_pkg::dim_t'(2);
    end else if (width_q > bsp_pkg::ResetWidth) begin
      w_eff = bsp_pkg::ResetWidth;
    end else begin
      w_eff = width_q;
    end
    if (height_q < bsp_pkg::dim_t'(2)) begin
      h_eff = bsp_pkg::dim_t'(2);
    end else if (height_q > bsp_pkg::ResetHeight) begin
      h_eff = bsp_pkg::ResetHeight;
    end else begin
      h_eff = height_q;
    end
  end

  assign w_last_cell = {w_eff[bsp_pkg::DimW-1:1], 1'b0} - bsp_pkg::dim_t'(1);
  assign h_last_cell = {h_eff[bsp_pkg::DimW-1:1], 1'b0} - bsp_pkg::dim_t'(1);
  assign col_last    = bsp_pkg::dim_t'(col_q) == (w_eff - bsp_pkg::dim_t'(1));
  assign row_last    = bsp_pkg::dim_t'(row_q) == (h_eff - bsp_pkg::dim_t'(1));

  // Even row: pair {odd, even} written on the odd column.
  // Odd row: pair read on the even column; data stays in the RAM output register
  // until the odd column arrives. Write and read of one entry are always on
  // different items, so no forwarding is needed.
  assign mem_we    = in_fire && !row_q[0] && col_q[0];
  assign mem_re    = in_fire && row_q[0] && !col_q[0];
  assign mem_wdata = {pixel_i.pixel, left_q};
  assign mem_addr  = col_q[bsp_pkg::ColW-1:1];

  bsp_ram #(
    .Width (bsp_pkg::PairW),
    .Depth (bsp_pkg::PairDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  // Cell positions: top-left, top-right, bottom-left, bottom-right
  assign cell0 = mem_rdata[bsp_pkg::PixW-1:0];
  assign cell1 = mem_rdata[bsp_pkg::PairW-1:bsp_pkg::PixW];
  assign cell2 = left_q;
  assign cell3 = pixel_i.pixel;
  assign sat0  = cell0 >= sat_q;
  assign sat1  = cell1 >= sat_q;
  assign sat2  = cell2 >= sat_q;
  assign sat3  = cell3 >= sat_q;

  always_comb begin
    case (pattern_q)
      bsp_pkg::PatRggb: begin
        red_raw = cell0; red_sat = sat0;
        blue_raw = cell3; blue_sat = sat3;
        g_a = cell1; g_b = cell2; green_sat = sat1 || sat2;
      end
      bsp_pkg::PatBggr: begin
        red_raw = cell3; red_sat = sat3;
        blue_raw = cell0; blue_sat = sat0;
        g_a = cell1; g_b = cell2; green_sat = sat1 || sat2;
      end
      bsp_pkg::PatGrbg: begin
        red_raw = cell1; red_sat = sat1;
        blue_raw = cell2; blue_sat = sat2;
        g_a = cell0; g_b = cell3; green_sat = sat0 || sat3;
      end
      default: begin
        red_raw = cell2; red_sat = sat2;
        blue_raw = cell1; blue_sat = sat1;
        g_a = cell0; g_b = cell3; green_sat = sat0 || sat3;
      end
    endcase
  end

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    pattern_d = pattern_q;
    sat_d     = sat_q;
    dim_write = 1'b0;
    if (cfg_we_i) begin
      case (bsp_pkg::cfg_idx_e'(cfg_idx_i))
        bsp_pkg::CfgImageWidth: begin
          width_d   = cfg_wdata_i[bsp_pkg::DimW-1:0];
          dim_write = 1'b1;
        end
        bsp_pkg::CfgImageHeight: begin
          height_d  = cfg_wdata_i[bsp_pkg::DimW-1:0];
          dim_write = 1'b1;
        end
        bsp_pkg::CfgBayerPat: pattern_d = bsp_pkg::pattern_e'(cfg_wdata_i[1:0]);
        bsp_pkg::CfgSatLevel: sat_d = cfg_wdata_i[bsp_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (in_fire && !col_q[0]) begin
      left_d = pixel_i.pixel;
    end
    if (dim_write) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + bsp_pkg::RowW'(1);
      end else begin
        col_d = col_q + bsp_pkg::ColW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    fend_d      = fend_q;
    if (superpixel_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      red_d       = red_sat ? bsp_pkg::SatOut : red_raw;
      blue_d      = blue_sat ? bsp_pkg::SatOut : blue_raw;
      green_d     = green_sat ? bsp_pkg::SatOutGreen
                              : ({1'b0, g_a} + {1'b0, g_b});
      fend_d      = (bsp_pkg::dim_t'(col_q) == w_last_cell) &&
                    (bsp_pkg::dim_t'(row_q) == h_last_cell);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= bsp_pkg::ResetWidth;
      height_q    <= bsp_pkg::ResetHeight;
      pattern_q   <= bsp_pkg::PatRggb;
      sat_q       <= bsp_pkg::ResetSat;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      pattern_q   <= pattern_d;
      sat_q       <= sat_d;
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    fend_q  <= fend_d;
  end

  assign superpixel_o.valid         = out_valid_q;
  assign superpixel_o.red           = red_q;
  assign superpixel_o.green_doubled = green_q;
  assign superpixel_o.blue          = blue_q;
  assign superpixel_o.frame_end     = fend_q;

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bsp_pkg::dim_t'(col_q) < w_eff)
    else $error("column counter beyond image width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bsp_pkg::dim_t'(row_q) < h_eff)
    else $error("row counter beyond image height");

  a_cell_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && row_q[0] && col_q[0]) |=> out_valid_q)
    else $error("closed cell did not load a result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !superpixel_o.ready) |-> !in_fire)
    else $error("item accepted while result register blocked");
`endif

endmodule

>>> rtl/bsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the Bayer 2x2 superpixel binning core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandItems  = 1200;

  typedef struct packed {
    bsp_pkg::pix_t   red;
    bsp_pkg::green_t green_doubled;
    bsp_pkg::pix_t   blue;
    logic            frame_end;
  } superpixel_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [bsp_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [bsp_pkg::CfgDataW-1:0] cfg_wdata_i;

  bsp_pixel_if pix_if ();
  bsp_super_if sp_if ();

  bayer_superpixel_split_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pixel_i      (pix_if),
    .superpixel_o (sp_if)
  );

  always #1 clk_i = ~clk_i;

  // Binning model state and its copy of the registers.
  bsp_pkg::pix_t     line_mem [bsp_pkg::MaxWidth];
  bsp_pkg::pix_t     held_px     = '0;
  int unsigned       mdl_col     = 0;
  int unsigned       mdl_row     = 0;
  bsp_pkg::dim_t     mdl_width   = bsp_pkg::ResetWidth;
  bsp_pkg::dim_t     mdl_height  = bsp_pkg::ResetHeight;
  bsp_pkg::pattern_e mdl_pattern = bsp_pkg::PatRggb;
  bsp_pkg::pix_t     mdl_sat     = bsp_pkg::ResetSat;

  bsp_pkg::pix_t pixel_q[$];
  superpixel_t   superpixel_q[$];

  int unsigned mismatches  = 0;
  int unsigned n_results   = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned cycles      = 0;
  bit          steady_flow = 1'b0;

  function automatic int unsigned eff_dim(input bsp_pkg::dim_t v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mostly back to back, sometimes short gaps, rarely long ones.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void flag_error(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, what);
  endfunction

  // Advance the model by one raw pixel; queue a superpixel when a cell closes.
  function automatic void bin_pixel(input bsp_pkg::pix_t px);
    int unsigned     w, h, r_pos, b_pos, k;
    bsp_pkg::pix_t   quad [4];
    bsp_pkg::pix_t   red, blue;
    bsp_pkg::green_t gsum;
    logic            sat_r, sat_g, sat_b, hit;
    superpixel_t     sp;
    w = eff_dim(mdl_width, bsp_pkg::MaxWidth);
    h = eff_dim(mdl_height, bsp_pkg::MaxHeight);
    if (!mdl_row[0]) begin
      line_mem[mdl_col] = px;
    end else if (!mdl_col[0]) begin
      held_px = px;
    end else begin
      quad[0] = line_mem[mdl_col-1];
      quad[1] = line_mem[mdl_col];
      quad[2] = held_px;
      quad[3] = px;
      case (mdl_pattern)
        bsp_pkg::PatRggb: begin r_pos = 0; b_pos = 3; end
        bsp_pkg::PatBggr: begin r_pos = 3; b_pos = 0; end
        bsp_pkg::PatGrbg: begin r_pos = 1; b_pos = 2; end
        default: begin r_pos = 2; b_pos = 1; end
      endcase
      red = '0; blue = '0; gsum = '0;
      sat_r = 1'b0; sat_g = 1'b0; sat_b = 1'b0;
      for (k = 0; k < 4; k++) begin
        hit = (quad[k] >= mdl_sat);
        if (k == r_pos) begin
          red   = quad[k];
          sat_r = sat_r | hit;
        end else if (k == b_pos) begin
          blue  = quad[k];
          sat_b = sat_b | hit;
        end else begin
          gsum  = gsum + bsp_pkg::GreenW'(quad[k]);
          sat_g = sat_g | hit;
        end
      end
      sp.red           = sat_r ? bsp_pkg::SatOut : red;
      sp.green_doubled = sat_g ? bsp_pkg::SatOutGreen : gsum;
      sp.blue          = sat_b ? bsp_pkg::SatOut : blue;
      sp.frame_end     = (mdl_col == (w & ~32'd1) - 1) && (mdl_row == (h & ~32'd1) - 1);
      superpixel_q.push_back(sp);
    end
    mdl_col++;
    if (mdl_col >= w) begin
      mdl_col = 0;
      mdl_row++;
      if (mdl_row >= h) mdl_row = 0;
    end
  endfunction

  // Pixel driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        bin_pixel(pix_if.pixel);
        void'(pixel_q.pop_front());
      end
      // An offered item is held until taken.
      if (!(pix_if.valid && !pix_if.ready)) begin
        if (send_gap != 0) begin
          send_gap--;
          pix_if.valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          pix_if.valid <= 1'b1;
          pix_if.pixel <= pixel_q[0];
          send_gap = steady_flow ? 0 : draw_gap();
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Superpixel monitor and back-pressure.
  always @(posedge clk_i) begin
    superpixel_t want;
    if (rst_ni) begin
      if (sp_if.valid && sp_if.ready) begin
        if (superpixel_q.size() == 0) begin
          flag_error($sformatf("unexpected superpixel r=%0d g=%0d b=%0d end=%0b",
                               sp_if.red, sp_if.green_doubled, sp_if.blue,
                               sp_if.frame_end));
        end else begin
          want = superpixel_q.pop_front();
          if (sp_if.red !== want.red || sp_if.green_doubled !== want.green_doubled ||
              sp_if.blue !== want.blue || sp_if.frame_end !== want.frame_end)
            flag_error($sformatf(
              "superpixel %0d: got r=%0d g=%0d b=%0d end=%0b, want r=%0d g=%0d b=%0d end=%0b",
              n_results, sp_if.red, sp_if.green_doubled, sp_if.blue, sp_if.frame_end,
              want.red, want.green_doubled, want.blue, want.frame_end));
        end
        n_results++;
        // Long hold-off so the output register fills and input ready drops.
        if (n_results == 50 || n_results == 200) hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        sp_if.ready <= 1'b0;
      end else if (steady_flow) begin
        sp_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        sp_if.ready <= 1'b0;
      end else begin
        sp_if.ready <= 1'b1;
        stall_left = draw_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("FAIL bayer_superpixel_split_core");
      $finish;
    end
  end

  task automatic write_reg(input bsp_pkg::cfg_idx_e idx,
                           input logic [bsp_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      bsp_pkg::CfgImageWidth: begin
        mdl_width = data[bsp_pkg::DimW-1:0];
        mdl_col = 0;
        mdl_row = 0;
      end
      bsp_pkg::CfgImageHeight: begin
        mdl_height = data[bsp_pkg::DimW-1:0];
        mdl_col = 0;
        mdl_row = 0;
      end
      bsp_pkg::CfgBayerPat: mdl_pattern = bsp_pkg::pattern_e'(data[1:0]);
      bsp_pkg::CfgSatLevel: mdl_sat = data;
      default: ;
    endcase
  endtask

  // Unused upper bits of each word get random junk.
  task automatic set_config(input int unsigned w, input int unsigned h,
                            input bsp_pkg::pattern_e pat, input bsp_pkg::pix_t sat);
    logic [bsp_pkg::CfgDataW-1:0] word;
    word = bsp_pkg::CfgDataW'(w);
    word[15:14] = 2'($urandom_range(0, 3));
    write_reg(bsp_pkg::CfgImageWidth, word);
    word = bsp_pkg::CfgDataW'(h);
    word[15:14] = 2'($urandom_range(0, 3));
    write_reg(bsp_pkg::CfgImageHeight, word);
    word = bsp_pkg::CfgDataW'($urandom_range(0, 65535));
    word[1:0] = pat;
    write_reg(bsp_pkg::CfgBayerPat, word);
    write_reg(bsp_pkg::CfgSatLevel, sat);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || superpixel_q.size() != 0 || pix_if.valid)
      @(posedge clk_i);
    // result register loads in the cycle after the last closing pixel
    repeat (4) @(posedge clk_i);
  endtask

  function automatic bsp_pkg::pix_t rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return bsp_pkg::SatOut;
    if (r == 2) return mdl_sat + bsp_pkg::pix_t'($urandom_range(0, 2)) - bsp_pkg::pix_t'(1);
    return bsp_pkg::pix_t'($urandom_range(0, 65535));
  endfunction

  function automatic bsp_pkg::pix_t rand_sat();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return bsp_pkg::SatOut;
    if (r <= 3) return bsp_pkg::ResetSat;
    if (r == 4) return bsp_pkg::pix_t'($urandom_range(1, 1000));
    return bsp_pkg::pix_t'($urandom_range(0, 65535));
  endfunction

  initial begin
    int unsigned w, h, n, split, i, rand_sent;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = bsp_pkg::CfgImageWidth;
    cfg_wdata_i  = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    sp_if.ready  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Threshold edges around the default level, both saturating positions.
    set_config(4, 2, bsp_pkg::PatRggb, bsp_pkg::ResetSat);
    pixel_q = '{16'd0, 16'd65535, 16'd65499, 16'd65500,
                16'd1, 16'd65534, 16'h5555, 16'hAAAA};
    drain();
    // Odd width and height: last column and row dropped; zero threshold.
    set_config(3, 3, bsp_pkg::PatBggr, 16'd0);
    pixel_q = '{16'h1234, 16'h8000, 16'h7FFF, 16'hFFFE, 16'h0001,
                16'hC3C3, 16'h00FF, 16'hFF00, 16'h4242};
    drain();
    // Dimensions below range clamp to 2; full-scale threshold.
    set_config(1, 0, bsp_pkg::PatGrbg, bsp_pkg::SatOut);
    pixel_q = '{16'd65535, 16'd65534, 16'd0, 16'd65535};
    drain();
    set_config(2, 2, bsp_pkg::PatGbrg, 16'd1);
    pixel_q = '{16'd0, 16'd0, 16'd1, 16'd0};
    drain();

    rand_sent = 0;
    while (rand_sent < RandItems) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(2, 24);
      h = $urandom_range(2, 9);
      set_config(w, h, bsp_pkg::pattern_e'($urandom_range(0, 3)), rand_sat());
      steady_flow = ($urandom_range(0, 3) == 0);
      // whole frames, then a partial one cut short by the next restart
      n = w * h * $urandom_range(1, 3) + $urandom_range(0, 2 * w);
      if (rand_sent + n > RandItems + 100) n = RandItems + 100 - rand_sent;
      split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : n;
      for (i = 0; i < n; i++) begin
        pixel_q.push_back(rand_pixel());
        // sender pauses mid-frame until every superpixel is out
        if (i + 1 == split) begin
          while (pixel_q.size() != 0 || superpixel_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
      rand_sent += n;
    end

    // Dimensions above range clamp to the maximum; partial frames only.
    steady_flow = 1'b1;
    set_config(16383, 2, bsp_pkg::PatRggb, bsp_pkg::ResetSat);
    for (i = 0; i < 200; i++) pixel_q.push_back(rand_pixel());
    drain();
    set_config(2, 16383, bsp_pkg::PatBggr, rand_sat());
    for (i = 0; i < 300; i++) pixel_q.push_back(rand_pixel());
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS bayer_superpixel_split_core");
    end else begin
      $display("FAIL bayer_superpixel_split_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bsp_pkg.sv
rtl/bsp_pixel_if.sv
rtl/bsp_super_if.sv
rtl/bsp_ram.sv
rtl/bayer_superpixel_split_core.sv
tb/tb_top.sv
